FILE: sv/dpers_pkg.sv
// dpers_pkg: shared constants, state encoding and control structs for the
// digit persistence core. No dependencies.
`timescale 1ns / 1ps

package dpers_pkg;

  // default width of the number
  localparam int NUMBER_WIDTH_DEF = 64;

  // decimal radix and result field widths
  localparam int RADIX     = 10;
  localparam int MUL_CNT_W = 4;
  localparam int ADD_CNT_W = 2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CONV,
    ST_DIGIT,
    ST_DONE
  } dpers_state_t;

  // commands from the sequencer to the decimal unit
  typedef struct packed {
    logic start;
    logic next_digit;
  } dpers_ctl_t;

  // status from the decimal unit to the sequencer
  typedef struct packed {
    logic conv_busy;
    logic empty;
  } dpers_sts_t;

endpackage

FILE: sv/dpers_in_if.sv
// dpers_in_if: valid/ready channel carrying one number per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface dpers_in_if #(
  parameter int NUMBER_WIDTH = 64
);
  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: sv/dpers_out_if.sv
// dpers_out_if: valid/ready channel carrying both persistence counts.
// Depends on nothing.
`timescale 1ns / 1ps

interface dpers_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] mul_persistence;
  logic [1:0] add_persistence;

  modport source (output valid, output mul_persistence, output add_persistence, input ready);
  modport sink   (input valid, input mul_persistence, input add_persistence, output ready);
endinterface

FILE: sv/dpers_bcd.sv
// dpers_bcd: bit-serial binary to decimal converter (shift and add-3), then
// hands out the decimal digits one per cycle while next_digit is asserted,
// least significant first. Depends on dpers_pkg.
`timescale 1ns / 1ps

module dpers_bcd #(
  parameter int NUMBER_WIDTH = dpers_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dpers_pkg::dpers_ctl_t   ctl,
  input  logic [NUMBER_WIDTH-1:0] value,
  output dpers_pkg::dpers_sts_t   sts,
  output logic [3:0]              digit
);
  import dpers_pkg::*;

  // decimal digits needed for the largest number of this width
  localparam int DIGITS = (NUMBER_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int CNT_W  = $clog2(NUMBER_WIDTH + 1);

  logic [BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [NUMBER_WIDTH-1:0] bin_r, bin_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [BCD_W-1:0]        bcd_adj;

  // add 3 to every digit of 5 or more before the next shift
  for (genvar g = 0; g < DIGITS; g++) begin : g_adj
    assign bcd_adj[4*g +: 4] = (bcd_r[4*g +: 4] >= 4'd5) ? bcd_r[4*g +: 4] + 4'd3
                                                          : bcd_r[4*g +: 4];
  end

  // conversion and digit shifting
  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    cnt_nxt = cnt_r;
    if (ctl.start) begin
      bcd_nxt = '0;
      bin_nxt = value;
      cnt_nxt = CNT_W'(NUMBER_WIDTH);
    end else if (cnt_r != '0) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[NUMBER_WIDTH-1]};
      bin_nxt = {bin_r[NUMBER_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end else if (ctl.next_digit) begin
      bcd_nxt = {4'd0, bcd_r[BCD_W-1:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // payload shift registers
  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    bin_r <= bin_nxt;
  end

  assign sts.conv_busy = (cnt_r != '0);
  assign sts.empty     = (bcd_r == '0);
  assign digit         = bcd_r[3:0];

endmodule

FILE: sv/digit_persistence_core.sv
// digit_persistence_core: multiplicative and additive digit persistence of
// one unsigned number. Depends on dpers_pkg, dpers_in_if, dpers_out_if and
// dpers_bcd.
//
// Usage: a number enters on in_if (valid/ready); one transaction on out_if
// carries its multiplicative and additive persistence. One number is worked
// on at a time; in_if.ready is high while the sequencer is idle, even while
// the previous result still waits in the output register.
// A round on a value runs in steps: a start, bit-serial decimal
// conversion, a walk of the digits through a narrow digit multiplier or
// adder, and a close of the round. Latency grows with the number of
// rounds and of digits. A new number is taken only once the previous one
// has left the sequencer; both chains share the one converter.
// Reset (synchronous, active low) returns to idle and drops out_if.valid.
// When the receiver stalls, the result holds in the output register and the
// next number, once accepted, finishes and then waits for that slot.
`timescale 1ns / 1ps

module digit_persistence_core #(
  parameter int NUMBER_WIDTH = dpers_pkg::NUMBER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dpers_in_if.sink    in_if,
  dpers_out_if.source out_if
);
  import dpers_pkg::*;

  localparam logic [NUMBER_WIDTH-1:0] RADIX_W = NUMBER_WIDTH'(RADIX);

  dpers_state_t            state_r, state_nxt;
  logic [NUMBER_WIDTH-1:0] work_r, work_nxt;
  logic [NUMBER_WIDTH-1:0] orig_r, orig_nxt;
  logic [NUMBER_WIDTH-1:0] acc_r, acc_nxt;
  logic                    phase_add_r, phase_add_nxt;
  logic [MUL_CNT_W-1:0]    mcnt_r, mcnt_nxt;
  logic [ADD_CNT_W-1:0]    acnt_r, acnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [MUL_CNT_W-1:0]    res_mul_r, res_mul_nxt;
  logic [ADD_CNT_W-1:0]    res_add_r, res_add_nxt;

  dpers_ctl_t              ctl;
  dpers_sts_t              sts;
  logic [3:0]              digit;
  logic [NUMBER_WIDTH+3:0] prod;

  // decimal conversion unit
  dpers_bcd #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .value (work_r),
    .sts   (sts),
    .digit (digit)
  );

  // one digit into the running product
  assign prod = acc_r * digit;

  // round sequencer
  always_comb begin
    state_nxt      = state_r;
    work_nxt       = work_r;
    orig_nxt       = orig_r;
    acc_nxt        = acc_r;
    phase_add_nxt  = phase_add_r;
    mcnt_nxt       = mcnt_r;
    acnt_nxt       = acnt_r;
    out_valid_nxt  = out_valid_r;
    res_mul_nxt    = res_mul_r;
    res_add_nxt    = res_add_r;
    ctl.start      = 1'b0;
    ctl.next_digit = 1'b0;
    in_if.ready    = 1'b0;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          work_nxt      = in_if.value;
          orig_nxt      = in_if.value;
          phase_add_nxt = 1'b0;
          mcnt_nxt      = '0;
          acnt_nxt      = '0;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (work_r < RADIX_W) begin
          if (!phase_add_r) begin
            // product chain done, restart on the original for the sum chain
            phase_add_nxt = 1'b1;
            work_nxt      = orig_r;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          ctl.start = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (!sts.conv_busy) begin
          acc_nxt   = phase_add_r ? '0 : NUMBER_WIDTH'(1);
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts.empty) begin
          // no nonzero digits left: round finished
          work_nxt = acc_r;
          if (phase_add_r) begin
            if (acnt_r != '1) acnt_nxt = acnt_r + 1'b1;
          end else begin
            if (mcnt_r != '1) mcnt_nxt = mcnt_r + 1'b1;
          end
          state_nxt = ST_CHECK;
        end else begin
          acc_nxt        = phase_add_r ? acc_r + NUMBER_WIDTH'(digit)
                                       : prod[NUMBER_WIDTH-1:0];
          ctl.next_digit = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          res_mul_nxt   = mcnt_r;
          res_add_nxt   = acnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    orig_r      <= orig_nxt;
    acc_r       <= acc_nxt;
    phase_add_r <= phase_add_nxt;
    mcnt_r      <= mcnt_nxt;
    acnt_r      <= acnt_nxt;
    res_mul_r   <= res_mul_nxt;
    res_add_r   <= res_add_nxt;
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.mul_persistence = res_mul_r;
  assign out_if.add_persistence = res_add_r;

endmodule
